### rtl/tria_pkg.sv
`timescale 1ns / 1ps

package tria_pkg;

	localparam int COORD_W       = 16;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int PROD_W        = 2 * DIFF_W;
	localparam int CROSS_W       = PROD_W + 1;
	localparam int DIST_W        = PROD_W;
	localparam int SQ_W          = PROD_W;
	localparam int HEIGHT_W      = 25;
	localparam int ROOT_W        = HEIGHT_W + 1;
	localparam int QUO_W         = 2 * ROOT_W;
	localparam int FRAC_BITS_DEF = 8;
	localparam int SIDES         = 3;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} vtx_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height_a;
		logic [HEIGHT_W-1:0] height_b;
		logic [HEIGHT_W-1:0] height_c;
		logic [SIDES-1:0]    zero_side_flags;
	} hgt_t;

	// doubled area, squared side lengths (bc, ac, ab) and zero-side marks
	typedef struct packed {
		logic [DIST_W-1:0]           d;
		logic [SIDES-1:0][SQ_W-1:0]  s;
		logic [SIDES-1:0]            zero;
	} pkt_t;

endpackage

### rtl/triangle_altitudes_core.sv
`timescale 1ns / 1ps

// triangle altitudes from three signed vertices
// vtx channel: one triangle per transfer (vtx_valid high, vtx_stall low).
// hgt channel: the three altitudes in fixed point with FRAC_BITS fraction
// bits, plus a flag per zero-length base side whose altitude reads 0.
// exactly one hgt transfer per vtx transfer, in order.
// throughput: one triangle per cycle unless hgt stalls, set by the
// fully pipelined divide and square-root lanes (one quotient or root
// bit per stage). path from a vtx transfer to hgt_valid: 3 front
// stages, the 2-entry queue, 2 stages for the area square, 79 lane
// stages and the output register.
// a stalled hgt holds its payload; the back pipeline freezes, the queue
// fills and then vtx_stall rises, so nothing is dropped.
// arst_n clears all valid state; no results are pending after reset.
module triangle_altitudes_core #(
	parameter int FRAC_BITS = tria_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vtx_valid,
	output logic           vtx_stall,
	input  tria_pkg::vtx_t vtx,
	output logic           hgt_valid,
	input  logic           hgt_stall,
	output tria_pkg::hgt_t hgt
);

	logic           push, full, pop, empty;
	tria_pkg::pkt_t wpkt, rpkt;

	tria_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.push      (push),
		.full      (full),
		.pkt       (wpkt)
	);

	tria_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wpkt),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (rpkt)
	);

	tria_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (rpkt),
		.empty     (empty),
		.pop       (pop),
		.hgt_valid (hgt_valid),
		.hgt_stall (hgt_stall),
		.hgt       (hgt)
	);

endmodule

### rtl/tria_front.sv
`timescale 1ns / 1ps

module tria_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_stall,
	input  tria_pkg::vtx_t    vtx,
	output logic              push,
	input  logic              full,
	output tria_pkg::pkt_t    pkt
);

	localparam int DW = tria_pkg::DIFF_W;
	localparam int PW = tria_pkg::PROD_W;
	localparam int CW = tria_pkg::CROSS_W;

	logic fe;
	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1, e3x_s1, e3y_s1;
	logic signed [PW-1:0] c1_s2, c2_s2;
	logic signed [PW-1:0] q1x_s2, q1y_s2, q2x_s2, q2y_s2, q3x_s2, q3y_s2;
	tria_pkg::pkt_t pkt_s3;
	logic signed [CW-1:0] xprod;
	logic [CW-1:0] mag;
	logic [tria_pkg::SIDES-1:0][tria_pkg::SQ_W-1:0] sq;

	assign fe        = !(v_s3 && full);
	assign vtx_stall = !fe;
	assign push      = v_s3 && !full;
	assign pkt       = pkt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fe) begin
			v_s1 <= vtx_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// edge vectors: e1 = b - a, e2 = c - a, e3 = c - b
	always_ff @(posedge clk) begin
		if (fe) begin
			e1x_s1 <= DW'(vtx.bx) - DW'(vtx.ax);
			e1y_s1 <= DW'(vtx.by_coord) - DW'(vtx.ay);
			e2x_s1 <= DW'(vtx.cx) - DW'(vtx.ax);
			e2y_s1 <= DW'(vtx.cy) - DW'(vtx.ay);
			e3x_s1 <= DW'(vtx.cx) - DW'(vtx.bx);
			e3y_s1 <= DW'(vtx.cy) - DW'(vtx.by_coord);
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			c1_s2  <= PW'(e1x_s1) * PW'(e2y_s1);
			c2_s2  <= PW'(e1y_s1) * PW'(e2x_s1);
			q1x_s2 <= PW'(e1x_s1) * PW'(e1x_s1);
			q1y_s2 <= PW'(e1y_s1) * PW'(e1y_s1);
			q2x_s2 <= PW'(e2x_s1) * PW'(e2x_s1);
			q2y_s2 <= PW'(e2y_s1) * PW'(e2y_s1);
			q3x_s2 <= PW'(e3x_s1) * PW'(e3x_s1);
			q3y_s2 <= PW'(e3y_s1) * PW'(e3y_s1);
		end
	end

	always_comb begin
		xprod = CW'(c1_s2) - CW'(c2_s2);
		mag   = xprod[CW-1] ? CW'(-xprod) : CW'(xprod);
		sq[0] = $unsigned(q3x_s2) + $unsigned(q3y_s2);
		sq[1] = $unsigned(q2x_s2) + $unsigned(q2y_s2);
		sq[2] = $unsigned(q1x_s2) + $unsigned(q1y_s2);
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			pkt_s3.d <= mag[tria_pkg::DIST_W-1:0];
			pkt_s3.s <= sq;
			for (int k = 0; k < tria_pkg::SIDES; k++) begin
				pkt_s3.zero[k] <= (sq[k] == '0);
			end
		end
	end

endmodule

### rtl/tria_fifo.sv
`timescale 1ns / 1ps

module tria_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tria_pkg::pkt_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tria_pkg::pkt_t rdata
);

	tria_pkg::pkt_t ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= wdata;
	end

endmodule

### rtl/tria_lane.sv
`timescale 1ns / 1ps

module tria_lane #(
	parameter int FRAC_BITS = tria_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [2*tria_pkg::DIST_W+2*FRAC_BITS-1:0] n,
	input  logic [tria_pkg::SQ_W-1:0]     s,
	input  logic                          zero,
	output logic [tria_pkg::HEIGHT_W-1:0] h,
	output logic                          zero_o
);

	localparam int NW  = 2 * tria_pkg::DIST_W + 2 * FRAC_BITS;
	localparam int SW  = tria_pkg::SQ_W;
	localparam int QW  = tria_pkg::QUO_W;
	localparam int RW  = tria_pkg::ROOT_W;
	localparam int HW  = tria_pkg::HEIGHT_W;
	localparam int LST = QW + RW;

	logic [NW-1:0] rem_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [SW-1:0] sd_s  [QW+1];
	logic [QW-1:0] rr_s  [RW+1];
	logic [RW-1:0] rt_s  [RW+1];
	logic          sat_s [LST+1];
	logic          z_s   [LST+1];

	// quotient above QW bits means the root saturates anyway
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n;
			quo_s[0] <= '0;
			sd_s[0]  <= s;
			sat_s[0] <= ((n >> QW) >= NW'(s));
			z_s[0]   <= zero;
		end
	end

	for (genvar i = 0; i < LST; i++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[i+1] <= sat_s[i];
				z_s[i+1]   <= z_s[i];
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int B = QW - 1 - i;
		logic [NW-1:0] sx;
		logic          ge;
		assign sx = NW'(sd_s[i]);
		assign ge = ((rem_s[i] >> B) >= sx);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - (sx << B) : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	// digit-by-digit square root on the quotient
	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		localparam int B = RW - 1 - j;
		logic [QW-1:0] r_in, trial;
		logic [RW-1:0] t_in;
		logic          ge;
		if (j == 0) begin : g_first
			assign r_in = quo_s[QW];
			assign t_in = '0;
		end else begin : g_next
			assign r_in = rr_s[j];
			assign t_in = rt_s[j];
		end
		assign trial = (QW'(t_in) << (B + 1)) | (QW'(1) << (2 * B));
		assign ge    = (r_in >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rr_s[j+1] <= ge ? r_in - trial : r_in;
				rt_s[j+1] <= ge ? (t_in | (RW'(1) << B)) : t_in;
			end
		end
	end

	always_comb begin
		priority if (z_s[LST]) h = '0;
		else if (sat_s[LST] || rt_s[RW][RW-1]) h = {HW{1'b1}};
		else h = rt_s[RW][HW-1:0];
	end

	assign zero_o = z_s[LST];

endmodule

### rtl/tria_back.sv
`timescale 1ns / 1ps

module tria_back #(
	parameter int FRAC_BITS = tria_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tria_pkg::pkt_t pkt,
	input  logic           empty,
	output logic           pop,
	output logic           hgt_valid,
	input  logic           hgt_stall,
	output tria_pkg::hgt_t hgt
);

	localparam int DW  = tria_pkg::DIST_W;
	localparam int K   = (DW + 1) / 2;
	localparam int DHW = DW - K;
	localparam int NW  = 2 * DW + 2 * FRAC_BITS;
	localparam int LAT = 1 + tria_pkg::QUO_W + tria_pkg::ROOT_W;
	localparam int NS  = tria_pkg::SIDES;

	logic be;
	logic v_s1, v_s2;
	logic [2*DHW-1:0]   hh_s1;
	logic [DHW+K-1:0]   hl_s1;
	logic [2*K-1:0]     ll_s1;
	logic [NS-1:0][tria_pkg::SQ_W-1:0] s_s1, s_s2;
	logic [NS-1:0]      z_s1, z_s2;
	logic [NW-1:0]      n_s2;
	logic               vd_s [LAT];
	logic [tria_pkg::HEIGHT_W-1:0] h [NS];
	logic [NS-1:0]      zo;
	logic               hgt_valid_q;
	tria_pkg::hgt_t     hgt_q;

	assign be        = !(hgt_valid_q && hgt_stall);
	assign pop       = be && !empty;
	assign hgt_valid = hgt_valid_q;
	assign hgt       = hgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hgt_valid_q <= 1'b0;
			for (int i = 0; i < LAT; i++) vd_s[i] <= 1'b0;
		end else if (be) begin
			v_s1    <= !empty;
			v_s2    <= v_s1;
			vd_s[0] <= v_s2;
			for (int i = 1; i < LAT; i++) vd_s[i] <= vd_s[i-1];
			hgt_valid_q <= vd_s[LAT-1];
		end
	end

	// d squared from three half-width partial products
	always_ff @(posedge clk) begin
		if (be) begin
			hh_s1 <= (2*DHW)'(pkt.d[DW-1:K]) * (2*DHW)'(pkt.d[DW-1:K]);
			hl_s1 <= (DHW+K)'(pkt.d[DW-1:K]) * (DHW+K)'(pkt.d[K-1:0]);
			ll_s1 <= (2*K)'(pkt.d[K-1:0]) * (2*K)'(pkt.d[K-1:0]);
			s_s1  <= pkt.s;
			z_s1  <= pkt.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			n_s2 <= ((NW'(hh_s1) << (2 * K)) + (NW'(hl_s1) << (K + 1)) + NW'(ll_s1))
				<< (2 * FRAC_BITS);
			s_s2 <= s_s1;
			z_s2 <= z_s1;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_lane
		tria_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (be),
			.n      (n_s2),
			.s      (s_s2[k]),
			.zero   (z_s2[k]),
			.h      (h[k]),
			.zero_o (zo[k])
		);
	end

	always_ff @(posedge clk) begin
		if (be) begin
			hgt_q.height_a        <= h[0];
			hgt_q.height_b        <= h[1];
			hgt_q.height_c        <= h[2];
			hgt_q.zero_side_flags <= zo;
		end
	end

endmodule

### rtl/tria_checker.sv
`timescale 1ns / 1ps

module tria_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           vtx_valid,
	input logic           vtx_stall,
	input logic           hgt_valid,
	input logic           hgt_stall,
	input tria_pkg::hgt_t hgt
);

	logic       in_x, out_x;
	logic [7:0] cnt_q;

	assign in_x  = vtx_valid && !vtx_stall;
	assign out_x = hgt_valid && !hgt_stall;

	// triangles accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else cnt_q <= cnt_q + 8'(in_x) - 8'(out_x);
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hgt_valid && hgt_stall |=> hgt_valid && $stable(hgt))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		hgt_valid |-> cnt_q != 8'd0)
		else $error("result without a pending triangle");

	a_zero_side: assert property (@(posedge clk) disable iff (!arst_n)
		hgt_valid |-> (!hgt.zero_side_flags[0] || hgt.height_a == '0)
			&& (!hgt.zero_side_flags[1] || hgt.height_b == '0)
			&& (!hgt.zero_side_flags[2] || hgt.height_c == '0))
		else $error("flagged side with non-zero altitude");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !hgt_valid)
		else $error("result valid right after reset");

endmodule

bind triangle_altitudes_core tria_checker u_chk (.*);

### tb/tb_triangle_altitudes_core.sv
`timescale 1ns / 1ps

module tb_triangle_altitudes_core;

	localparam int FRAC       = tria_pkg::FRAC_BITS_DEF;
	localparam int HW         = tria_pkg::HEIGHT_W;
	localparam int NSD        = tria_pkg::SIDES;
	localparam int CRD_W      = tria_pkg::COORD_W;
	localparam int N_RANDOM   = 1400;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 200;
	localparam int HOLD_LEN   = 400;
	localparam logic [HW-1:0] H_MAX = '1;

	typedef struct {
		tria_pkg::vtx_t v;
		bit             typed;
		tria_pkg::hgt_t h;
	} tri_row_t;

	logic clk;
	logic arst_n;
	logic vtx_valid;
	logic vtx_stall;
	tria_pkg::vtx_t vtx;
	logic hgt_valid;
	logic hgt_stall;
	tria_pkg::hgt_t hgt;

	tria_pkg::hgt_t pending_heights[$];
	tri_row_t dir_rows[$];
	int       fail_cnt;
	int       mism_cnt;
	int       idle_cycles;
	int       sent_cnt;
	bit       quiet;
	bit       hold_req;
	bit       stim_done;

	triangle_altitudes_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.hgt_valid (hgt_valid),
		.hgt_stall (hgt_stall),
		.hgt       (hgt)
	);

	always #10 clk = ~clk;

	// largest h with h*h*s <= n, saturated to the output width
	function automatic logic [HW-1:0] root_div(logic [127:0] n, logic [127:0] s);
		logic [127:0] h;
		logic [127:0] c;
		h = 0;
		for (int b = 31; b >= 0; b--) begin
			c = h | (128'd1 << b);
			if (c * c * s <= n)
				h = c;
		end
		return (h > H_MAX) ? H_MAX : h[HW-1:0];
	endfunction

	function automatic tria_pkg::hgt_t tri_heights(tria_pkg::vtx_t v);
		longint       ax, ay, bx, by, cx, cy, cr;
		logic [127:0] d, n;
		logic [127:0] s [NSD];
		logic [HW-1:0] h [NSD];
		tria_pkg::hgt_t r;
		ax = v.ax; ay = v.ay; bx = v.bx; by = v.by_coord; cx = v.cx; cy = v.cy;
		cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		d = (cr < 0) ? -cr : cr;
		n = (d * d) << (2 * FRAC);
		s[0] = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
		s[1] = (cx - ax) * (cx - ax) + (cy - ay) * (cy - ay);
		s[2] = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
		r.zero_side_flags = '0;
		for (int k = 0; k < NSD; k++) begin
			if (s[k] == 0) begin
				h[k] = '0;
				r.zero_side_flags[k] = 1'b1;
			end else begin
				h[k] = root_div(n, s[k]);
			end
		end
		r.height_a = h[0];
		r.height_b = h[1];
		r.height_c = h[2];
		return r;
	endfunction

	function automatic tri_row_t mk_row(int ax, int ay, int bx, int by, int cx, int cy,
			bit typed = 0, int ha = 0, int hb = 0, int hc = 0, int fl = 0);
		tri_row_t r;
		r.v.ax = CRD_W'(ax);
		r.v.ay = CRD_W'(ay);
		r.v.bx = CRD_W'(bx);
		r.v.by_coord = CRD_W'(by);
		r.v.cx = CRD_W'(cx);
		r.v.cy = CRD_W'(cy);
		r.typed = typed;
		r.h.height_a = HW'(ha);
		r.h.height_b = HW'(hb);
		r.h.height_c = HW'(hc);
		r.h.zero_side_flags = NSD'(fl);
		return r;
	endfunction

	function automatic logic [CRD_W-1:0] pick_coord(int mode);
		case (mode)
			0: return CRD_W'($urandom);
			1: return CRD_W'($urandom_range(16) - 8);
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
		endcase
	endfunction

	function automatic tria_pkg::vtx_t rand_tri();
		tria_pkg::vtx_t v;
		int   kind, dx, dy, t, u;
		kind = $urandom_range(9);
		v.ax = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		v.ay = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		v.bx = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		v.by_coord = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		v.cx = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		v.cy = pick_coord(kind < 5 ? 0 : (kind < 7 ? 1 : 2));
		if (kind == 8) begin
			// collinear points along a small direction
			dx = $urandom_range(200) - 100;
			dy = $urandom_range(200) - 100;
			t = $urandom_range(40) - 20;
			u = $urandom_range(40) - 20;
			v.ax = CRD_W'($urandom_range(20000) - 10000);
			v.ay = CRD_W'($urandom_range(20000) - 10000);
			v.bx = CRD_W'(int'(v.ax) + t * dx);
			v.by_coord = CRD_W'(int'(v.ay) + t * dy);
			v.cx = CRD_W'(int'(v.ax) + u * dx);
			v.cy = CRD_W'(int'(v.ay) + u * dy);
		end else if (kind == 9) begin
			// two vertices coincide
			case ($urandom_range(2))
				0: begin v.bx = v.ax; v.by_coord = v.ay; end
				1: begin v.cx = v.ax; v.cy = v.ay; end
				default: begin v.cx = v.bx; v.cy = v.by_coord; end
			endcase
		end
		return v;
	endfunction

	task automatic send_tri(tria_pkg::vtx_t v, tria_pkg::hgt_t h);
		vtx <= v;
		vtx_valid <= 1'b1;
		@(posedge clk);
		while (vtx_stall)
			@(posedge clk);
		pending_heights.push_back(h);
		sent_cnt++;
	endtask

	task automatic sender_gap();
		int n, r;
		r = $urandom_range(99);
		if (quiet || r < 60)
			return;
		n = (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
		vtx_valid <= 1'b0;
		vtx <= rand_tri();
		repeat (n) @(posedge clk);
	endtask

	// stimulus
	initial begin
		tri_row_t row;
		tria_pkg::vtx_t v;
		clk = 0;
		arst_n = 0;
		vtx_valid = 0;
		vtx = '0;
		hgt_stall = 0;
		fail_cnt = 0;
		mism_cnt = 0;
		sent_cnt = 0;
		quiet = 0;
		hold_req = 0;
		stim_done = 0;

		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 3'b111));
		dir_rows.push_back(mk_row(5, 5, 5, 5, 9, -3, 1, 0, 0, 0, 3'b100));
		dir_rows.push_back(mk_row(-7, 2, 4, 4, -7, 2, 1, 0, 0, 0, 3'b010));
		dir_rows.push_back(mk_row(1, 9, -3, 6, -3, 6, 1, 0, 0, 0, 3'b001));
		dir_rows.push_back(mk_row(0, 0, 1, 1, 2, 2, 1, 0, 0, 0, 3'b000));
		dir_rows.push_back(mk_row(0, 0, 1, 0, 0, 1, 1, 181, 256, 256, 3'b000));
		dir_rows.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
			1, 0, 0, 0, 3'b111));
		dir_rows.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767,
			1, 0, 0, 0, 3'b111));
		dir_rows.push_back(mk_row(-32768, -32768, 32767, -32768, -32768, 32767));
		dir_rows.push_back(mk_row(32767, 32767, -32768, 32767, 32767, -32768));
		dir_rows.push_back(mk_row(-32768, 32767, 32767, -32768, 0, 0));
		dir_rows.push_back(mk_row(-32768, -32768, 32767, 32767, 32767, 32766));
		dir_rows.push_back(mk_row(0, 0, 32767, 0, 0, 1));
		dir_rows.push_back(mk_row(-32768, 0, 32767, 0, 0, 32767));
		dir_rows.push_back(mk_row(3, -4, -100, 250, 77, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_tri(row.v, row.typed ? row.h : tri_heights(row.v));
			sender_gap();
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = ((i / 200) % 3 == 1);
			if (i == 700)
				hold_req = 1;
			v = rand_tri();
			send_tri(v, tri_heights(v));
			sender_gap();
		end
		vtx_valid <= 1'b0;
		stim_done = 1;

		while (pending_heights.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result check and receiver stall
	initial begin
		tria_pkg::hgt_t exp_h;
		int   stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && hgt_valid && !hgt_stall) begin
				if (pending_heights.size() == 0) begin
					fail_cnt++;
					if (mism_cnt++ < 10)
						$display("unexpected transfer: %h", hgt);
				end else begin
					exp_h = pending_heights.pop_front();
					if (hgt.height_a !== exp_h.height_a || hgt.height_b !== exp_h.height_b ||
							hgt.height_c !== exp_h.height_c ||
							hgt.zero_side_flags !== exp_h.zero_side_flags) begin
						fail_cnt++;
						if (mism_cnt++ < 10)
							$display("mismatch: exp a=%0d b=%0d c=%0d f=%b got a=%0d b=%0d c=%0d f=%b",
								exp_h.height_a, exp_h.height_b, exp_h.height_c,
								exp_h.zero_side_flags, hgt.height_a, hgt.height_b,
								hgt.height_c, hgt.zero_side_flags);
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				hgt_stall <= 1'b1;
			end else if (!quiet && $urandom_range(99) < 30) begin
				stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
					: $urandom_range(3, 1);
				stall_left--;
				hgt_stall <= 1'b1;
			end else begin
				hgt_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (hgt_valid && !hgt_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
